FILE: sv/cpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact point estimator package
// Shared constants, sequencer command type and fixed-point helper functions.
// ----------------------------------------------------------------------------
package cpe_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GAIN_W      = 31;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FORGET  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADAPT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEAK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_X = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Z = 3'd6;

    localparam logic [30:0] FORGET_RST = 31'd65536;
    localparam logic [30:0] ADAPT_RST  = 31'd65536;
    localparam logic [30:0] LEAK_RST   = 31'd0;
    localparam logic [31:0] STEP_RST   = 32'd4294967;

    localparam logic [1:0] COMP_LAST  = 2'd2;
    localparam logic [2:0] ENTRY_LAST = 3'd5;
    localparam logic [3:0] DIV_LAST   = 4'd8;   // nine radix-16 digits

    typedef enum logic [4:0] {
        OP_SQ,
        OP_OFF,
        OP_BETAL,
        OP_DTL,
        OP_CR1,
        OP_CR2,
        OP_BETAQ,
        OP_DTQ,
        OP_U0,
        OP_U1,
        OP_U2,
        OP_GAMMA,
        OP_DIV,
        OP_KAPPA,
        OP_DTRATE,
        OP_DTKR,
        OP_RELOAD,
        OP_OUT
    } cpe_op_t;

    typedef struct packed {
        cpe_op_t    op;
        logic [2:0] idx;
        logic       last;
        logic       mul_en;
        logic       post_en;
        logic       load;
    } cpe_cmd_t;

    function automatic logic [1:0] inc3(input logic [1:0] c);
        return (c == COMP_LAST) ? 2'd0 : c + 2'd1;
    endfunction

    // upper-triangle storage: xx, xy, xz, yy, yz, zz
    function automatic logic [1:0] l_row(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] l_col(input logic [2:0] k);
        logic [1:0] c;
        unique case (k)
            3'd0:       c = 2'd0;
            3'd1, 3'd3: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic l_is_diag(input logic [2:0] k);
        return (k == 3'd0) || (k == 3'd3) || (k == 3'd5);
    endfunction

    function automatic logic [2:0] l_index(input logic [1:0] i, input logic [1:0] j);
        logic [2:0] k;
        unique case ({i, j})
            4'b0000:          k = 3'd0;
            4'b0001, 4'b0100: k = 3'd1;
            4'b0010, 4'b1000: k = 3'd2;
            4'b0101:          k = 3'd3;
            4'b0110, 4'b1001: k = 3'd4;
            default:          k = 3'd5;
        endcase
        return k;
    endfunction

    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // quotient digit of a partial remainder below 320 divided by 20
    function automatic logic [3:0] div20_digit(input logic [8:0] v);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (v >= 9'(20 * k))
                d = 4'(k);
        end
        return d;
    endfunction

endpackage

FILE: sv/cpe_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one force/torque sample per transaction.
// ----------------------------------------------------------------------------
interface cpe_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic               restart;

    modport source (output valid, force_x, force_y, force_z, torque_x, torque_y,
                    torque_z, restart, input ready);
    modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y,
                    torque_z, restart, output ready);
endinterface

FILE: sv/cpe_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one contact point estimate per transaction.
// ----------------------------------------------------------------------------
interface cpe_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               saturated;

    modport source (output valid, point_x, point_y, point_z, saturated, input ready);
    modport sink   (input valid, point_x, point_y, point_z, saturated, output ready);
endinterface

FILE: sv/cpe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact point estimator controller
// Sequences the micro-operations of one update over the shared multiplier.
// ----------------------------------------------------------------------------
module cpe_ctrl
    import cpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_restart,
    output logic     in_ready,
    input  logic     out_ready,
    output logic     out_valid,
    output cpe_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t     state_reg, state_next;
    cpe_op_t    op_reg, op_next, op_adv;
    logic [2:0] idx_reg, idx_next, idx_adv;
    logic [3:0] cnt_reg, cnt_next, cnt_adv;
    logic       half_reg, half_next;
    logic       out_valid_reg, out_valid_next;
    logic       needs_mul;

    // successor of the current micro-operation
    always_comb
    begin
        op_adv  = op_reg;
        idx_adv = idx_reg;
        cnt_adv = cnt_reg;
        unique case (op_reg)
            OP_SQ:
            begin
                if (idx_reg[1:0] == COMP_LAST)
                begin
                    idx_adv = 3'd0;
                    op_adv  = l_is_diag(3'd0) ? OP_BETAL : OP_OFF;
                end
                else
                    idx_adv = idx_reg + 3'd1;
            end
            OP_OFF:   op_adv = OP_BETAL;
            OP_BETAL: op_adv = OP_DTL;
            OP_DTL:
            begin
                if (idx_reg == ENTRY_LAST)
                begin
                    idx_adv = 3'd0;
                    op_adv  = OP_CR1;
                end
                else
                begin
                    idx_adv = idx_reg + 3'd1;
                    op_adv  = l_is_diag(idx_reg + 3'd1) ? OP_BETAL : OP_OFF;
                end
            end
            OP_CR1:   op_adv = OP_CR2;
            OP_CR2:   op_adv = OP_BETAQ;
            OP_BETAQ: op_adv = OP_DTQ;
            OP_DTQ:
            begin
                if (idx_reg[1:0] == COMP_LAST)
                begin
                    idx_adv = 3'd0;
                    op_adv  = OP_U0;
                end
                else
                begin
                    idx_adv = idx_reg + 3'd1;
                    op_adv  = OP_CR1;
                end
            end
            OP_U0:    op_adv = OP_U1;
            OP_U1:    op_adv = OP_U2;
            OP_U2:    op_adv = OP_GAMMA;
            OP_GAMMA:
            begin
                op_adv  = OP_DIV;
                cnt_adv = 4'd0;
            end
            OP_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_adv = 4'd0;
                    if (idx_reg[1:0] == COMP_LAST)
                    begin
                        idx_adv = 3'd0;
                        op_adv  = OP_KAPPA;
                    end
                    else
                    begin
                        idx_adv = idx_reg + 3'd1;
                        op_adv  = OP_U0;
                    end
                end
                else
                    cnt_adv = cnt_reg + 4'd1;
            end
            OP_KAPPA:  op_adv = OP_DTRATE;
            OP_DTRATE: op_adv = OP_DTKR;
            OP_DTKR:
            begin
                if (idx_reg[1:0] == COMP_LAST)
                    op_adv = OP_OUT;
                else
                begin
                    idx_adv = idx_reg + 3'd1;
                    op_adv  = OP_KAPPA;
                end
            end
            OP_RELOAD: op_adv = OP_OUT;
            OP_OUT:    op_adv = OP_OUT;
            default:   op_adv = OP_OUT;
        endcase
    end

    assign needs_mul = !((op_reg == OP_DIV) || (op_reg == OP_RELOAD) || (op_reg == OP_OUT));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = op_reg;
        cmd.idx        = idx_reg;
        cmd.last       = (cnt_reg == DIV_LAST);
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                    op_next    = in_restart ? OP_RELOAD : OP_SQ;
                    idx_next   = 3'd0;
                    cnt_next   = 4'd0;
                    half_next  = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (needs_mul && !half_reg)
                begin
                    cmd.mul_en = 1'b1;
                    half_next  = 1'b1;
                end
                else if (!((op_reg == OP_OUT) && out_valid_reg && !out_ready))
                begin
                    cmd.post_en = 1'b1;
                    half_next   = 1'b0;
                    op_next     = op_adv;
                    idx_next    = idx_adv;
                    cnt_next    = cnt_adv;
                    if (op_reg == OP_OUT)
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_OUT;
            idx_reg       <= 3'd0;
            cnt_reg       <= 4'd0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/cpe_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact point estimator datapath
// Configuration, estimator state, one shared multiplier and a digit divider.
// ----------------------------------------------------------------------------
module cpe_dpath
    import cpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cpe_cmd_t               cmd,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [31:0]     force_x,
    input  logic signed [31:0]     force_y,
    input  logic signed [31:0]     force_z,
    input  logic signed [31:0]     torque_x,
    input  logic signed [31:0]     torque_y,
    input  logic signed [31:0]     torque_z,
    output logic signed [31:0]     point_x,
    output logic signed [31:0]     point_y,
    output logic signed [31:0]     point_z,
    output logic                   saturated
);

    logic [GAIN_W-1:0]  forget_reg, adapt_reg, leak_reg;
    logic [31:0]        step_reg;
    logic signed [31:0] start_reg [3];

    logic signed [31:0] l_reg [6];
    logic signed [31:0] l_next [6];
    logic signed [31:0] q_reg [3];
    logic signed [31:0] q_next [3];
    logic signed [31:0] rate_reg [3];
    logic signed [31:0] rate_next [3];
    logic signed [31:0] r_reg [3];
    logic signed [31:0] r_next [3];
    logic               sat_reg, sat_next;

    logic signed [31:0] f_reg [3];
    logic signed [31:0] t_reg [3];
    logic signed [31:0] sq_reg [3];
    logic signed [31:0] sq_next [3];
    logic signed [31:0] tmp_reg, tmp_next;
    logic signed [31:0] br_reg, br_next;
    logic signed [35:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [35:0]        divx_reg, divx_next;
    logic [4:0]         rem_reg, rem_next;
    logic [28:0]        quo_reg, quo_next;
    logic signed [65:0] prod_reg;
    logic signed [31:0] point_reg [3];
    logic signed [31:0] point_next [3];
    logic               osat_reg, osat_next;

    logic [1:0]         comp, ca, cb, krow, kcol, kra, krb, uj;
    logic [2:0]         l_sel;
    logic [1:0]         r_sel;
    logic               is_u;
    logic signed [32:0] opa, opb;
    logic signed [65:0] prod_w;
    logic signed [63:0] pq64, pd64, pqx, accx;
    logic signed [31:0] pq;
    logic               pq_ovf;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    assign comp = cmd.idx[1:0];
    assign ca   = inc3(comp);
    assign cb   = inc3(ca);
    assign krow = l_row(cmd.idx);
    assign kcol = l_col(cmd.idx);
    assign kra  = inc3(krow);
    assign krb  = inc3(kra);
    assign is_u = (cmd.op == OP_U0) || (cmd.op == OP_U1) || (cmd.op == OP_U2);

    always_comb
    begin
        if (cmd.op == OP_U1)
            uj = 2'd1;
        else if (cmd.op == OP_U2)
            uj = 2'd2;
        else
            uj = 2'd0;
    end

    assign l_sel = is_u ? l_index(comp, uj) : cmd.idx;
    assign r_sel = is_u ? uj : comp;

    // operand select for the shared multiplier
    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.op)
            OP_SQ:
            begin
                opa = sx33(f_reg[comp]);
                opb = sx33(f_reg[comp]);
            end
            OP_OFF:
            begin
                opa = sx33(f_reg[krow]);
                opb = sx33(f_reg[kcol]);
            end
            OP_BETAL:
            begin
                opa = {2'b00, forget_reg};
                opb = sx33(l_reg[l_sel]);
            end
            OP_DTL, OP_DTQ:
            begin
                opa = sx33(br_reg);
                opb = {1'b0, step_reg};
            end
            OP_CR1:
            begin
                opa = sx33(f_reg[ca]);
                opb = sx33(t_reg[cb]);
            end
            OP_CR2:
            begin
                opa = sx33(f_reg[cb]);
                opb = sx33(t_reg[ca]);
            end
            OP_BETAQ:
            begin
                opa = {2'b00, forget_reg};
                opb = sx33(q_reg[comp]);
            end
            OP_U0, OP_U1, OP_U2:
            begin
                opa = sx33(l_reg[l_sel]);
                opb = sx33(r_reg[r_sel]);
            end
            OP_GAMMA:
            begin
                opa = {2'b00, adapt_reg};
                opb = sx33(tmp_reg);
            end
            OP_KAPPA:
            begin
                opa = {2'b00, leak_reg};
                opb = sx33(r_reg[r_sel]);
            end
            OP_DTRATE:
            begin
                opa = sx33(rate_reg[comp]);
                opb = {1'b0, step_reg};
            end
            OP_DTKR:
            begin
                opa = sx33(tmp_reg);
                opb = {1'b0, step_reg};
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod_w = opa * opb;

    // arithmetic shifts round toward minus infinity
    assign pq64   = {{14{prod_reg[65]}}, prod_reg[65:16]};
    assign pd64   = {{30{prod_reg[65]}}, prod_reg[65:32]};
    assign pq     = sat32(pq64);
    assign pq_ovf = ovf32(pq64);
    assign pqx    = sx64(pq);
    assign accx   = {{28{acc_reg[35]}}, acc_reg};

    always_comb
    begin
        logic signed [63:0] s1;
        logic signed [63:0] s2;
        logic signed [31:0] drive;
        logic               ovf;
        logic [8:0]         dv;
        logic [8:0]         rem_full;
        logic [3:0]         dg;
        logic [32:0]        qf;

        s1 = '0;
        s2 = '0;
        drive = '0;
        ovf = 1'b0;
        dv = '0;
        rem_full = '0;
        dg = '0;
        qf = '0;

        l_next     = l_reg;
        q_next     = q_reg;
        rate_next  = rate_reg;
        r_next     = r_reg;
        sq_next    = sq_reg;
        point_next = point_reg;
        tmp_next   = tmp_reg;
        br_next    = br_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        divx_next  = divx_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        osat_next  = osat_reg;
        sat_next   = sat_reg;

        if (cmd.load)
            sat_next = 1'b0;
        else if (cmd.post_en)
        begin
            unique case (cmd.op)
                OP_SQ:
                begin
                    sq_next[comp] = pq;
                    ovf = pq_ovf;
                end
                OP_OFF:
                begin
                    s1 = -pqx;
                    tmp_next = sat32(s1);
                    ovf = pq_ovf | ovf32(s1);
                end
                OP_BETAL:
                begin
                    if (l_is_diag(cmd.idx))
                    begin
                        s1 = sx64(sq_reg[kra]) + sx64(sq_reg[krb]);
                        drive = sat32(s1);
                        ovf = ovf32(s1);
                    end
                    else
                        drive = tmp_reg;
                    s2 = sx64(drive) - pqx;
                    br_next = sat32(s2);
                    ovf = ovf | pq_ovf | ovf32(s2);
                end
                OP_DTL:
                begin
                    s1 = sx64(l_reg[l_sel]) + pd64;
                    l_next[l_sel] = sat32(s1);
                    ovf = ovf32(s1);
                end
                OP_CR1, OP_KAPPA:
                begin
                    tmp_next = pq;
                    ovf = pq_ovf;
                end
                OP_CR2:
                begin
                    s1 = sx64(tmp_reg) - pqx;
                    tmp_next = sat32(s1);
                    ovf = pq_ovf | ovf32(s1);
                end
                OP_BETAQ:
                begin
                    s1 = sx64(tmp_reg) - pqx;
                    br_next = sat32(s1);
                    ovf = pq_ovf | ovf32(s1);
                end
                OP_DTQ:
                begin
                    s1 = sx64(q_reg[comp]) + pd64;
                    q_next[comp] = sat32(s1);
                    ovf = ovf32(s1);
                end
                OP_U0:
                begin
                    s1 = sx64(q_reg[comp]) + pqx;
                    acc_next = s1[35:0];
                    ovf = pq_ovf;
                end
                OP_U1:
                begin
                    s1 = accx + pqx;
                    acc_next = s1[35:0];
                    ovf = pq_ovf;
                end
                OP_U2:
                begin
                    s1 = accx + pqx;
                    tmp_next = sat32(s1);
                    ovf = pq_ovf | ovf32(s1);
                end
                OP_GAMMA:
                begin
                    // 19*rate - g, then floor division by 20 via the magnitude (biased by 19 when negative)
                    s2 = sx64(rate_reg[comp]);
                    s1 = (s2 <<< 4) + (s2 <<< 1) + s2 - pqx;
                    neg_next = s1[63];
                    if (s1[63])
                        s1 = 64'sd19 - s1;
                    divx_next = s1[35:0];
                    rem_next = '0;
                    quo_next = '0;
                    ovf = pq_ovf;
                end
                OP_DIV:
                begin
                    dv = {rem_reg, divx_reg[35:32]};
                    dg = div20_digit(dv);
                    rem_full = dv - ({5'b0, dg} * 9'd20);
                    rem_next = rem_full[4:0];
                    divx_next = {divx_reg[31:0], 4'b0000};
                    qf = {quo_reg, dg};
                    quo_next = qf[28:0];
                    if (cmd.last)
                    begin
                        s1 = {31'b0, qf};
                        if (neg_reg)
                            s1 = -s1;
                        rate_next[comp] = sat32(s1);
                        ovf = ovf32(s1);
                    end
                end
                OP_DTRATE:
                begin
                    s1 = sx64(r_reg[comp]) + pd64;
                    acc_next = s1[35:0];
                end
                OP_DTKR:
                begin
                    s1 = accx - pd64;
                    r_next[comp] = sat32(s1);
                    ovf = ovf32(s1);
                end
                OP_RELOAD:
                begin
                    for (int c = 0; c < 6; c++)
                        l_next[c] = '0;
                    for (int c = 0; c < 3; c++)
                    begin
                        q_next[c] = '0;
                        rate_next[c] = '0;
                        s1 = -sx64(start_reg[c]);
                        r_next[c] = sat32(s1);
                        ovf = ovf | ovf32(s1);
                    end
                end
                OP_OUT:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        s1 = -sx64(r_reg[c]);
                        point_next[c] = sat32(s1);
                        ovf = ovf | ovf32(s1);
                    end
                    osat_next = sat_reg | ovf;
                end
                default: ovf = 1'b0;
            endcase
            sat_next = sat_reg | ovf;
        end
    end

    // configuration and estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forget_reg <= FORGET_RST;
            adapt_reg  <= ADAPT_RST;
            leak_reg   <= LEAK_RST;
            step_reg   <= STEP_RST;
            for (int c = 0; c < 3; c++)
            begin
                start_reg[c] <= '0;
                q_reg[c]     <= '0;
                rate_reg[c]  <= '0;
                r_reg[c]     <= '0;
            end
            for (int c = 0; c < 6; c++)
                l_reg[c] <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FORGET:  forget_reg   <= cfg_data[GAIN_W-1:0];
                    REG_ADAPT:   adapt_reg    <= cfg_data[GAIN_W-1:0];
                    REG_LEAK:    leak_reg     <= cfg_data[GAIN_W-1:0];
                    REG_STEP:    step_reg     <= cfg_data;
                    REG_START_X: start_reg[0] <= cfg_data;
                    REG_START_Y: start_reg[1] <= cfg_data;
                    REG_START_Z: start_reg[2] <= cfg_data;
                    default:     forget_reg   <= forget_reg;
                endcase
            end
            l_reg    <= l_next;
            q_reg    <= q_next;
            rate_reg <= rate_next;
            r_reg    <= r_next;
            sat_reg  <= sat_next;
        end
    end

    // working registers and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            f_reg[0] <= force_x;
            f_reg[1] <= force_y;
            f_reg[2] <= force_z;
            t_reg[0] <= torque_x;
            t_reg[1] <= torque_y;
            t_reg[2] <= torque_z;
        end
        if (cmd.mul_en)
            prod_reg <= prod_w;
        sq_reg    <= sq_next;
        tmp_reg   <= tmp_next;
        br_reg    <= br_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        divx_reg  <= divx_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        point_reg <= point_next;
        osat_reg  <= osat_next;
    end

    assign point_x   = point_reg[0];
    assign point_y   = point_reg[1];
    assign point_z   = point_reg[2];
    assign saturated = osat_reg;

endmodule

FILE: sv/contact_point_estimator_unit.sv
`timescale 1ns / 1ps
// Operation: one sample at a time; a restart sample reloads the state and reports the start point.
// A normal sample is bounded by the single shared 33x33 multiplier doing 51 products,
//   each with an issue step and an apply step, plus the division by 20 at one
//   radix-16 digit per cycle. The next sample is taken while a result waits.
// Reset: estimator state cleared, configuration at its defaults, result channel empty.
// ----------------------------------------------------------------------------
// Contact point estimator unit
// Adaptive contact point estimate from force/torque samples, Q16.16 saturating.
// ----------------------------------------------------------------------------
module contact_point_estimator_unit
    import cpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    cpe_sample_if.sink             sample,
    cpe_result_if.source           result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cpe_cmd_t cmd;

    cpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_restart (sample.restart),
        .in_ready   (sample.ready),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .cmd        (cmd)
    );

    cpe_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .force_x   (sample.force_x),
        .force_y   (sample.force_y),
        .force_z   (sample.force_z),
        .torque_x  (sample.torque_x),
        .torque_y  (sample.torque_y),
        .torque_z  (sample.torque_z),
        .point_x   (result.point_x),
        .point_y   (result.point_y),
        .point_z   (result.point_z),
        .saturated (result.saturated)
    );

endmodule

FILE: sv/cpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact point estimator checker
// Port-level assertions on sample and result transactions.
// ----------------------------------------------------------------------------
module cpe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] point_x,
    input logic [31:0] point_y,
    input logic [31:0] point_z,
    input logic        saturated
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(point_z) && $stable(saturated))
        else $error("result changed while stalled");

    // one sample in flight at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while busy");

    // no result in the cycle right after a sample transaction
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

    // a new result means the unit is free for the next sample
    a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("unit busy after result");

endmodule

bind contact_point_estimator_unit cpe_checker u_cpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .point_x   (result.point_x),
    .point_y   (result.point_y),
    .point_z   (result.point_z),
    .saturated (result.saturated)
);

FILE: dv/cpe_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel notes
// The sample and result interfaces come from the RTL tree; this file only
// holds the transaction types shared by the testbench top.
// ----------------------------------------------------------------------------
package cpe_tb_types;

    typedef struct {
        logic signed [31:0] fx, fy, fz, tx, ty, tz;
        logic               restart;
    } sample_t;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic               sat;
    } point_t;

endpackage

FILE: dv/tb_contact_point_estimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contact point estimator testbench
// Drives force/torque samples with random idling, predicts each contact point
// with a fixed-point model of the estimator and checks every result.
// ----------------------------------------------------------------------------
module tb_contact_point_estimator_unit;
    import cpe_pkg::*;
    import cpe_tb_types::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cpe_sample_if smp();
    cpe_result_if res();

    contact_point_estimator_unit dut (
        .clk(clk), .rst_n(rst_n), .sample(smp.sink), .result(res.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of configuration and state
    logic [30:0] m_beta, m_gamma, m_kappa;
    logic [31:0] m_dt;
    logic signed [31:0] m_start [3];
    logic signed [31:0] m_lmat [6];
    logic signed [31:0] m_qv [3];
    logic signed [31:0] m_rate [3];
    logic signed [31:0] m_est [3];
    bit m_sat;

    sample_t pending_samples[$];
    point_t  expected_points[$];
    int  mismatches;
    int  cycles;
    bit  quiet_tail;
    bit  hold_sink;

    function automatic logic signed [31:0] sat_q(input logic signed [95:0] v);
        if (v > 96'sd2147483647) begin m_sat = 1; return 32'sh7fffffff; end
        if (v < -96'sd2147483648) begin m_sat = 1; return 32'sh80000000; end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [95:0] p;
        p = 96'(a) * 96'(b);
        return sat_q(p >>> 16);
    endfunction

    function automatic logic signed [95:0] mul_dt(input logic signed [31:0] a);
        logic signed [95:0] p;
        p = 96'(a) * $signed({64'd0, m_dt});
        return p >>> 32;
    endfunction

    function automatic int tri_idx(input int i, input int j);
        int k;
        if (i > j) begin k = i; i = j; j = k; end
        if (i == 0) return j;
        if (i == 1) return j + 2;
        return 5;
    endfunction

    function automatic void reload_state();
        for (int i = 0; i < 6; i++) m_lmat[i] = 0;
        for (int i = 0; i < 3; i++)
        begin
            m_qv[i] = 0;
            m_rate[i] = 0;
            m_est[i] = sat_q(-96'(m_start[i]));
        end
    endfunction

    function automatic point_t estimate_point(input sample_t s);
        logic signed [31:0] f[3], t[3], sq[3], cr[3], u[3], drive, br, g, kr;
        logic signed [95:0] acc, n;
        point_t pt;
        f = '{s.fx, s.fy, s.fz};
        t = '{s.tx, s.ty, s.tz};
        m_sat = 0;
        if (s.restart) reload_state();
        else
        begin
            for (int i = 0; i < 3; i++) sq[i] = mul_q(f[i], f[i]);
            for (int i = 0; i < 3; i++)
                for (int j = i; j < 3; j++)
                begin
                    if (i == j) drive = sat_q(96'(sq[(i+1)%3]) + 96'(sq[(i+2)%3]));
                    else drive = sat_q(-96'(mul_q(f[i], f[j])));
                    br = sat_q(-96'(mul_q($signed({1'b0, m_beta}), m_lmat[tri_idx(i, j)]))
                               + 96'(drive));
                    m_lmat[tri_idx(i, j)] = sat_q(96'(m_lmat[tri_idx(i, j)]) + mul_dt(br));
                end
            for (int i = 0; i < 3; i++)
                cr[i] = sat_q(96'(mul_q(f[(i+1)%3], t[(i+2)%3]))
                              - 96'(mul_q(f[(i+2)%3], t[(i+1)%3])));
            for (int i = 0; i < 3; i++)
            begin
                br = sat_q(-96'(mul_q($signed({1'b0, m_beta}), m_qv[i])) + 96'(cr[i]));
                m_qv[i] = sat_q(96'(m_qv[i]) + mul_dt(br));
            end
            for (int i = 0; i < 3; i++)
            begin
                acc = 96'(m_qv[i]);
                for (int j = 0; j < 3; j++) acc += 96'(mul_q(m_lmat[tri_idx(i, j)], m_est[j]));
                u[i] = sat_q(acc);
            end
            for (int i = 0; i < 3; i++)
            begin
                g = mul_q($signed({1'b0, m_gamma}), u[i]);
                n = 96'sd19 * 96'(m_rate[i]) - 96'(g);
                // floor division by 20
                if (n >= 0) m_rate[i] = sat_q(n / 20);
                else m_rate[i] = sat_q(-((-n + 19) / 20));
            end
            for (int i = 0; i < 3; i++)
            begin
                kr = mul_q($signed({1'b0, m_kappa}), m_est[i]);
                m_est[i] = sat_q(96'(m_est[i]) + mul_dt(m_rate[i]) - mul_dt(kr));
            end
        end
        pt.px = sat_q(-96'(m_est[0]));
        pt.py = sat_q(-96'(m_est[1]));
        pt.pz = sat_q(-96'(m_est[2]));
        pt.sat = m_sat;
        return pt;
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    // sample driver
    int src_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid <= 0;
            src_gap = 0;
        end
        else
        begin
            if (smp.valid && smp.ready)
            begin
                expected_points.push_back(estimate_point(pending_samples.pop_front()));
                src_gap = (!quiet_tail && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
            end
            else if (!smp.valid && src_gap > 0) src_gap--;
            if ((!smp.valid || smp.ready) && src_gap == 0 && pending_samples.size() > 0
                && !(smp.valid && smp.ready && pending_samples.size() == 0))
            begin
                smp.valid    <= 1;
                smp.force_x  <= pending_samples[0].fx;
                smp.force_y  <= pending_samples[0].fy;
                smp.force_z  <= pending_samples[0].fz;
                smp.torque_x <= pending_samples[0].tx;
                smp.torque_y <= pending_samples[0].ty;
                smp.torque_z <= pending_samples[0].tz;
                smp.restart  <= pending_samples[0].restart;
            end
            else if (smp.ready || !smp.valid) smp.valid <= 0;
        end
    end

    // result monitor with random backpressure
    int sink_gap;
    always @(posedge clk or negedge rst_n)
    begin
        point_t e;
        if (!rst_n)
        begin
            res.ready <= 0;
            sink_gap = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected point %0d %0d %0d",
                                                   res.point_x, res.point_y, res.point_z);
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (e.px !== res.point_x || e.py !== res.point_y || e.pz !== res.point_z
                        || e.sat !== res.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("point mismatch: exp %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                                     e.px, e.py, e.pz, e.sat, res.point_x, res.point_y,
                                     res.point_z, res.saturated);
                    end
                end
            end
            if (sink_gap > 0) sink_gap--;
            else if (!quiet_tail && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 13);
            res.ready <= !hold_sink && sink_gap == 0;
        end
    end

    function automatic logic signed [31:0] rnd_val(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $signed($urandom_range(0, 32'h1fff_ffff)) - 32'sh1000_0000;
        endcase
    endfunction

    function automatic sample_t rnd_sample(input int mode, input bit rs);
        sample_t s;
        s.fx = rnd_val(mode); s.fy = rnd_val(mode); s.fz = rnd_val(mode);
        s.tx = rnd_val(mode); s.ty = rnd_val(mode); s.tz = rnd_val(mode);
        s.restart = rs;
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            REG_FORGET:  m_beta  = val[30:0];
            REG_ADAPT:   m_gamma = val[30:0];
            REG_LEAK:    m_kappa = val[30:0];
            REG_STEP:    m_dt    = val;
            REG_START_X: m_start[0] = val;
            REG_START_Y: m_start[1] = val;
            REG_START_Z: m_start[2] = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || smp.valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic push_run(input int n, input int mode);
        for (int k = 0; k < n; k++)
            pending_samples.push_back(rnd_sample(mode, $urandom_range(0, 30) == 0));
    endtask

    // watchdog
    initial
    begin
        wait (cycles > 400000);
        $display("status: fail");
        $finish;
    end

    // long receiver stall, counted here while the driver keeps offering
    initial
    begin
        hold_sink = 0;
        wait (cycles > 2000);
        hold_sink = 1;
        repeat (600) @(posedge clk);
        hold_sink = 0;
    end

    initial
    begin
        sample_t s;
        logic signed [31:0] ext[6];
        cycles = 0; mismatches = 0; quiet_tail = 0;
        cfg_we = 0; cfg_index = 0; cfg_data = 0;
        smp.valid = 0; smp.force_x = 0; smp.force_y = 0; smp.force_z = 0;
        smp.torque_x = 0; smp.torque_y = 0; smp.torque_z = 0; smp.restart = 0;
        res.ready = 0;
        m_beta = FORGET_RST; m_gamma = ADAPT_RST; m_kappa = LEAK_RST; m_dt = STEP_RST;
        m_start = '{0, 0, 0};
        reload_state();
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, restart with extreme start points
        ext = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh10000};
        for (int k = 0; k < 6; k++)
        begin
            s.fx = ext[k]; s.fy = ext[(k+1)%6]; s.fz = ext[(k+2)%6];
            s.tx = ext[(k+3)%6]; s.ty = ext[(k+4)%6]; s.tz = ext[(k+5)%6];
            s.restart = 0;
            pending_samples.push_back(s);
        end
        push_run(4, 1);
        drain();
        write_reg(REG_START_X, 32'h80000000);
        write_reg(REG_START_Y, 32'h7fffffff);
        write_reg(REG_START_Z, 32'h00018000);
        write_reg(3'd7, 32'hffffffff);
        pending_samples.push_back(rnd_sample(1, 1));
        pending_samples.push_back(rnd_sample(0, 0));
        pending_samples.push_back(rnd_sample(1, 1));
        push_run(6, 1);
        drain();

        // settings sweep; each phase starts from a restart
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_FORGET, 0); write_reg(REG_ADAPT, 32'h7fffffff);
                         write_reg(REG_LEAK, 32'h7fffffff); write_reg(REG_STEP, 32'hffffffff); end
                1: begin write_reg(REG_FORGET, 32'h7fffffff); write_reg(REG_ADAPT, 0);
                         write_reg(REG_LEAK, 0); write_reg(REG_STEP, 0); end
                2: begin write_reg(REG_FORGET, 32'h8000); write_reg(REG_ADAPT, 32'h40000);
                         write_reg(REG_LEAK, 32'h1000); write_reg(REG_STEP, 32'h01000000); end
                default: begin write_reg(REG_FORGET, $urandom); write_reg(REG_ADAPT, $urandom);
                         write_reg(REG_LEAK, $urandom_range(0, 32'h20000));
                         write_reg(REG_STEP, $urandom); end
            endcase
            write_reg(REG_START_X, rnd_val(1));
            write_reg(REG_START_Y, rnd_val(2));
            write_reg(REG_START_Z, rnd_val(0));
            pending_samples.push_back(rnd_sample(1, 1));
            push_run(75, ph % 3);
            if (ph == 4) quiet_tail = 1;
            drain();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
